// ===== sv/lane_argmax_select_core_assert.svh =====
// Assertion macros shared by the lane arg-max RTL.
`ifndef LANE_ARGMAX_SELECT_CORE_ASSERT_SVH
`define LANE_ARGMAX_SELECT_CORE_ASSERT_SVH

// cons must hold in the same cycle as ante
`define LASEL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// cond must never be true
`define LASEL_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

// ===== sv/lasel_pkg.sv =====
// Package: widths, item and queue status types for the lane arg-max block.
`default_nettype none

package lasel_pkg;

    localparam int LANES          = 4;
    localparam int WEIGHT_W       = 32;
    localparam int INDEX_IN_W     = 16;
    localparam int INDEX_OUT_W    = 16;
    localparam int INDEX_BITS_DEF = 16;
    localparam int QDEPTH         = 2;

    typedef logic [WEIGHT_W-1:0]   t_weight;
    typedef logic [INDEX_IN_W-1:0] t_index_in;

    // one candidate vector as it travels front -> queue -> back
    typedef struct packed {
        logic                        last;
        t_weight   [LANES-1:0]       weight;
        t_index_in [LANES-1:0]       index;
    } t_item;

    typedef struct packed {
        logic full;
        logic nonempty;
    } t_q_status;

endpackage

`default_nettype wire

// ===== sv/lane_argmax_select_core.sv =====
// Top level: streaming per-lane arg-max with batch reduction on the last beat.
//
//  channel  dir  handshake          payload
//  -------  ---  -----------------  ------------------------------------------
//  in       in   i_valid / o_stall  i_weight_lane0..3, i_index_lane0..3, i_last
//  out      out  o_valid / i_stall  o_best_index, o_found
//
//  Sustained rate: one beat per cycle while the output is not stalled, set by the per-lane compare-select.
//  After its last beat is taken, a result passes through the front register,
//  queue, lane update and two reduction tree levels.
//  Synchronous active-low reset empties the queue and clears the lane store.
//  A stall on the output freezes the back end; the 2-entry queue and front
//  register then fill before o_stall rises.
`default_nettype none

module lane_argmax_select_core #(
    parameter int INDEX_BITS = lasel_pkg::INDEX_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  lasel_pkg::t_weight                i_weight_lane0,
    input  lasel_pkg::t_weight                i_weight_lane1,
    input  lasel_pkg::t_weight                i_weight_lane2,
    input  lasel_pkg::t_weight                i_weight_lane3,
    input  lasel_pkg::t_index_in              i_index_lane0,
    input  lasel_pkg::t_index_in              i_index_lane1,
    input  lasel_pkg::t_index_in              i_index_lane2,
    input  lasel_pkg::t_index_in              i_index_lane3,
    input  logic                              i_last,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [lasel_pkg::INDEX_OUT_W-1:0] o_best_index,
    output logic                              o_found
);
    import lasel_pkg::*;

`include "lane_argmax_select_core_assert.svh"

    t_weight   in_weight [LANES];
    t_index_in in_index  [LANES];
    logic      push;
    logic      pop;
    t_item     front_item;
    t_item     q_item;
    t_q_status q_status;

    // gather the lane ports into arrays
    assign in_weight[0] = i_weight_lane0;
    assign in_weight[1] = i_weight_lane1;
    assign in_weight[2] = i_weight_lane2;
    assign in_weight[3] = i_weight_lane3;
    assign in_index[0]  = i_index_lane0;
    assign in_index[1]  = i_index_lane1;
    assign in_index[2]  = i_index_lane2;
    assign in_index[3]  = i_index_lane3;

    // front: registers each beat and tags it with its batch-end flag
    lasel_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_weight   (in_weight),
        .i_index    (in_index),
        .i_last     (i_last),
        .o_stall    (o_stall),
        .o_push     (push),
        .o_item     (front_item),
        .i_q_status (q_status)
    );

    // queue: lets the front keep taking beats while the back end waits
    lasel_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (front_item),
        .i_pop    (pop),
        .o_item   (q_item),
        .o_status (q_status)
    );

    // back: lane store update and arg-max tree with the output register
    lasel_back #(
        .INDEX_BITS (INDEX_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_status   (q_status),
        .i_item       (q_item),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_best_index (o_best_index),
        .o_found      (o_found)
    );

    // the last beat fills every lane, so a result always has a candidate
    `LASEL_ASSERT_IMP(a_result_found, o_valid, o_found, "result without candidate")
    // queue must never be written while full
    `LASEL_ASSERT_NEVER(a_no_overflow, push && q_status.full, "queue overflow")
    // back end must never read an empty queue
    `LASEL_ASSERT_IMP(a_no_underflow, pop, q_status.nonempty, "queue underflow")

endmodule

`default_nettype wire

// ===== sv/lasel_front.sv =====
// Front stage: takes input beats and registers them as classified items.
`default_nettype none

module lasel_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  lasel_pkg::t_weight    i_weight [lasel_pkg::LANES],
    input  lasel_pkg::t_index_in  i_index [lasel_pkg::LANES],
    input  logic                  i_last,
    output logic                  o_stall,
    output logic                  o_push,
    output lasel_pkg::t_item      o_item,
    input  lasel_pkg::t_q_status  i_q_status
);
    import lasel_pkg::*;

    logic  r_valid;
    t_item r_item;
    t_item n_item;
    logic  accept;

    assign o_stall = r_valid && i_q_status.full;
    assign o_push  = r_valid && !i_q_status.full;
    assign accept  = i_valid && !o_stall;
    assign o_item  = r_item;

    always_comb begin
        n_item.last = i_last;
        for (int l = 0; l < LANES; l++) begin
            n_item.weight[l] = i_weight[l];
            n_item.index[l]  = i_index[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

endmodule

`default_nettype wire

// ===== sv/lasel_queue.sv =====
// Short FIFO that decouples the front stage from the lane update.
`default_nettype none

module lasel_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  lasel_pkg::t_item      i_item,
    input  logic                  i_pop,
    output lasel_pkg::t_item      o_item,
    output lasel_pkg::t_q_status  o_status
);
    import lasel_pkg::*;

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);

    t_item             r_mem [QDEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(QDEPTH - 1)) begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

    assign o_item            = r_mem[r_rd_ptr];
    assign o_status.full     = (r_count == CNT_W'(QDEPTH));
    assign o_status.nonempty = (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

// ===== sv/lasel_back.sv =====
// Back end: per-lane best update, then a two-level registered arg-max tree.
`default_nettype none

module lasel_back #(
    parameter int INDEX_BITS = lasel_pkg::INDEX_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  lasel_pkg::t_q_status            i_q_status,
    input  lasel_pkg::t_item                i_item,
    output logic                            o_pop,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [lasel_pkg::INDEX_OUT_W-1:0] o_best_index,
    output logic                            o_found
);
    import lasel_pkg::*;

    localparam int PAIRS = LANES / 2;

    typedef struct packed {
        logic                  filled;
        t_weight               weight;
        logic [INDEX_BITS-1:0] index;
    } t_cand;

    // b (higher lane) wins on a strictly greater weight or when a is unfilled
    function automatic t_cand pick(input t_cand a, input t_cand b);
        if (b.filled && (!a.filled || (b.weight > a.weight))) begin
            return b;
        end
        return a;
    endfunction

    t_cand r_lane [LANES];
    t_cand n_lane [LANES];
    t_cand r_snap [LANES];
    t_cand r_l1   [PAIRS];
    t_cand r_out;
    logic  r_snap_valid;
    logic  r_l1_valid;
    logic  r_out_valid;
    logic  en;

    assign en    = !r_out_valid || !i_stall;
    assign o_pop = en && i_q_status.nonempty;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            if (!r_lane[l].filled || (i_item.weight[l] > r_lane[l].weight)) begin
                n_lane[l].filled = 1'b1;
                n_lane[l].weight = i_item.weight[l];
                n_lane[l].index  = INDEX_BITS'(i_item.index[l]);
            end else begin
                n_lane[l] = r_lane[l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < LANES; l++) begin
                r_lane[l] <= '0;
            end
            r_snap_valid <= 1'b0;
            r_l1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_pop) begin
                for (int l = 0; l < LANES; l++) begin
                    r_lane[l] <= i_item.last ? t_cand'('0) : n_lane[l];
                end
            end
            if (en) begin
                r_snap_valid <= o_pop && i_item.last;
                r_l1_valid   <= r_snap_valid;
                r_out_valid  <= r_l1_valid;
            end
        end
    end

    // payload of the reduction tree
    always_ff @(posedge i_clk) begin
        if (o_pop && i_item.last) begin
            for (int l = 0; l < LANES; l++) begin
                r_snap[l] <= n_lane[l];
            end
        end
        if (en) begin
            for (int p = 0; p < PAIRS; p++) begin
                r_l1[p] <= pick(r_snap[2*p], r_snap[2*p+1]);
            end
            r_out <= pick(r_l1[0], r_l1[1]);
        end
    end

    assign o_valid      = r_out_valid;
    assign o_found      = r_out.filled;
    assign o_best_index = r_out.filled ? INDEX_OUT_W'(r_out.index) : '0;

endmodule

`default_nettype wire
